[rtl/core/pcst_pkg.sv]
// Shared types and constants for the parity count segment tree unit.
// Depends on nothing; used by pcst_engine and parity_count_segment_tree_unit.
`default_nettype none

package pcst_pkg;

   // Array size and derived tree geometry.
   localparam int MAX_ELEMENTS = 1024;
   localparam int NODE_W       = $clog2(2 * MAX_ELEMENTS);
   localparam int NODES        = 2 * MAX_ELEMENTS;

   // Fixed field widths of the request and response channels.
   localparam int OP_W    = 2;
   localparam int IDX_W   = 10;
   localparam int VALUE_W = 32;
   localparam int CNT_W   = 11;

   // Width that can hold both the element count register and MAX_ELEMENTS.
   localparam int LIM_W = (CNT_W > $clog2(MAX_ELEMENTS + 1)) ? CNT_W
                                                            : $clog2(MAX_ELEMENTS + 1);

   localparam logic [CNT_W-1:0] ELEMENT_COUNT_RESET = CNT_W'(1024);

   // Operation codes; code 3 is accepted and ignored.
   typedef enum logic [OP_W-1:0] {
      OP_SET  = 2'd0,
      OP_EVEN = 2'd1,
      OP_ODD  = 2'd2
   } pcst_op_type;

   // Tree sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QUERY
   } pcst_state_type;

   // Command from the front end to the tree sequencer.
   typedef struct packed {
      logic             upd;
      logic             qry;
      logic [IDX_W-1:0] idx;
      logic             parity;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } pcst_cmd_type;

   // Status from the tree sequencer.
   typedef struct packed {
      logic             ready;
      logic             done;
      logic [CNT_W-1:0] odd;
   } pcst_res_type;

endpackage

`default_nettype wire

[rtl/core/pcst_engine.sv]
// Tree sequencer: holds the odd-count tree in a synchronous memory and walks it.
// Depends on pcst_pkg for geometry, command and status types.
`default_nettype none

module pcst_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pcst_pkg::pcst_cmd_type cmd,
   output pcst_pkg::pcst_res_type     res
);

   localparam int NW = pcst_pkg::NODE_W;
   localparam int CW = pcst_pkg::CNT_W;

   // Node memory: one write port and two registered read ports.
   logic [CW-1:0] mem [0:pcst_pkg::NODES-1];
   logic          we;
   logic [NW-1:0] wa;
   logic [CW-1:0] wd;
   logic [NW-1:0] ra0;
   logic [NW-1:0] ra1;
   logic [CW-1:0] rd0_ff;
   logic [CW-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd0_ff <= mem[ra0];
      rd1_ff <= mem[ra1];
   end

   // Sequencer registers.
   pcst_pkg::pcst_state_type state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [NW-1:0] node_ff, node_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [NW:0]   a_ff, a_in;
   logic [NW:0]   b_ff, b_in;
   logic          pa_ff, pa_in;
   logic          pb_ff, pb_in;
   logic [CW-1:0] sum_ff, sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcst_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      node_ff <= node_in;
      cur_ff  <= cur_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      sum_ff  <= sum_in;
   end

   // Leaf of an incoming command and the combinational terms of the tree walk.
   logic [NW-1:0] leaf;
   logic [NW-1:0] parent;
   logic [CW-1:0] psum;
   logic [CW-1:0] acc;
   logic [NW:0]   b_dec;

   assign leaf   = NW'(pcst_pkg::MAX_ELEMENTS) + NW'(cmd.idx);
   assign parent = node_ff >> 1;
   assign psum   = cur_ff + rd0_ff;
   assign acc    = sum_ff + (pa_ff ? rd0_ff : '0) + (pb_ff ? rd1_ff : '0);
   assign b_dec  = b_ff - (NW + 1)'(1);

   // Next state and memory control.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      node_in  = node_ff;
      cur_in   = cur_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      sum_in   = sum_ff;
      we       = 1'b0;
      wa       = parent;
      wd       = psum;
      ra0      = node_ff ^ NW'(1);
      ra1      = b_dec[NW-1:0];
      res.ready = 1'b0;
      res.done  = 1'b0;
      res.odd   = acc;
      unique case (state_ff)
         pcst_pkg::ST_CLEAR: begin
            // One node zeroed per cycle after reset.
            we     = 1'b1;
            wa     = clr_ff;
            wd     = '0;
            clr_in = clr_ff + NW'(1);
            if (clr_ff == '1) begin
               state_in = pcst_pkg::ST_IDLE;
            end
         end
         pcst_pkg::ST_IDLE: begin
            res.ready = 1'b1;
            if (cmd.upd) begin
               // Write the leaf parity and fetch its sibling.
               we       = 1'b1;
               wa       = leaf;
               wd       = CW'(cmd.parity);
               ra0      = leaf ^ NW'(1);
               node_in  = leaf;
               cur_in   = CW'(cmd.parity);
               state_in = pcst_pkg::ST_UPDATE;
            end else if (cmd.qry) begin
               a_in     = (NW + 1)'(pcst_pkg::MAX_ELEMENTS) + (NW + 1)'(cmd.lo);
               b_in     = (NW + 1)'(pcst_pkg::MAX_ELEMENTS) + (NW + 1)'(cmd.hi)
                          + (NW + 1)'(1);
               pa_in    = 1'b0;
               pb_in    = 1'b0;
               sum_in   = '0;
               state_in = pcst_pkg::ST_QUERY;
            end
         end
         pcst_pkg::ST_UPDATE: begin
            // Sibling data is here: write the parent, fetch the parent's sibling.
            we = 1'b1;
            if (parent == NW'(1)) begin
               state_in = pcst_pkg::ST_IDLE;
            end else begin
               node_in = parent;
               cur_in  = psum;
               ra0     = parent ^ NW'(1);
            end
         end
         pcst_pkg::ST_QUERY: begin
            // Fold in last level's reads and issue this level's boundary reads.
            sum_in = acc;
            if (a_ff < b_ff) begin
               pa_in = a_ff[0];
               pb_in = b_ff[0];
               ra0   = a_ff[NW-1:0];
               ra1   = b_dec[NW-1:0];
               a_in  = (a_ff + (NW + 1)'(a_ff[0])) >> 1;
               b_in  = (b_ff - (NW + 1)'(b_ff[0])) >> 1;
            end else begin
               pa_in    = 1'b0;
               pb_in    = 1'b0;
               res.done = 1'b1;
               state_in = pcst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcst_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/parity_count_segment_tree_unit.sv]
// Top level of the parity count segment tree unit: channels, range clipping,
// result register. Depends on pcst_pkg and pcst_engine.
//
// Usage:
//  - req_* carries one operation per transfer: set an element's parity, or
//    count even or odd elements over an inclusive range. rsp_* returns one
//    count per query; sets and operation code 3 return nothing.
//  - csr_write_enable/csr_write_data write element_count; queries clip the
//    right bound to min(element_count, MAX_ELEMENTS) - 1.
//  - A set writes the leaf and then each node on its path up to the root, one
//    tree level at a time, each a read-modify-write on the node memory.
//  - A query walks at most log2(MAX_ELEMENTS) + 1 levels, one per cycle using
//    both memory read ports, then folds in the last reads; the count is
//    registered into rsp when the walk ends, and no new request is taken until
//    the walk has finished. Empty ranges answer 0 at once without touching the
//    tree.
//  - After reset the node memory is cleared one node per cycle, during which
//    req_ready stays low; csr writes are taken as usual.
//  - A finished result waits in rsp; one more query may run behind it into a
//    holding register. req_ready is low while that too is full or the tree is busy.
`default_nettype none

module parity_count_segment_tree_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [pcst_pkg::OP_W-1:0]    req_operation,
   input  wire logic [pcst_pkg::IDX_W-1:0]   req_index,
   input  wire logic [pcst_pkg::VALUE_W-1:0] req_value,
   input  wire logic [pcst_pkg::IDX_W-1:0]   req_left_bound,
   input  wire logic [pcst_pkg::IDX_W-1:0]   req_right_bound,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [pcst_pkg::CNT_W-1:0]        rsp_count,
   input  wire logic                         csr_write_enable,
   input  wire logic [pcst_pkg::CNT_W-1:0]   csr_write_data
);

   localparam int LW = pcst_pkg::LIM_W;
   localparam int CW = pcst_pkg::CNT_W;

   // Element count register.
   logic [CW-1:0] elem_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_count_ff <= pcst_pkg::ELEMENT_COUNT_RESET;
      end else if (csr_write_enable) begin
         elem_count_ff <= csr_write_data;
      end
   end

   pcst_pkg::pcst_cmd_type cmd;
   pcst_pkg::pcst_res_type eng;

   pcst_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (eng)
   );

   // Range clipping for the incoming request.
   logic [LW-1:0] limit;
   logic [LW-1:0] last;
   logic [LW-1:0] rb_clip;
   logic [LW-1:0] lb_wide;
   logic [LW-1:0] len_wide;
   logic          empty;
   logic          is_set;
   logic          is_query;
   logic          accept;

   assign limit   = (LW'(elem_count_ff) > LW'(pcst_pkg::MAX_ELEMENTS))
                    ? LW'(pcst_pkg::MAX_ELEMENTS) : LW'(elem_count_ff);
   assign last    = limit - LW'(1);
   assign rb_clip = (LW'(req_right_bound) > last) ? last : LW'(req_right_bound);
   assign lb_wide = LW'(req_left_bound);
   assign empty   = (limit == '0) || (lb_wide > rb_clip);
   assign len_wide = rb_clip - lb_wide + LW'(1);

   assign is_set   = (req_operation == pcst_pkg::OP_SET);
   assign is_query = (req_operation == pcst_pkg::OP_EVEN)
                     || (req_operation == pcst_pkg::OP_ODD);

   logic hold_valid_ff;
   assign req_ready = eng.ready && !hold_valid_ff;
   assign accept    = req_valid && req_ready;

   // Command to the tree sequencer, formed in the cycle of the transfer.
   always_comb begin
      cmd.upd    = accept && is_set
                   && (LW'(req_index) < LW'(pcst_pkg::MAX_ELEMENTS));
      cmd.qry    = accept && is_query && !empty;
      cmd.idx    = req_index;
      cmd.parity = req_value[0];
      cmd.lo     = req_left_bound;
      cmd.hi     = rb_clip[pcst_pkg::IDX_W-1:0];
   end

   // Query context kept while the tree is walked.
   logic          odd_op_ff;
   logic [CW-1:0] len_ff;
   logic          qry_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qry_pend_ff <= 1'b0;
      end else if (cmd.qry) begin
         qry_pend_ff <= 1'b1;
      end else if (eng.done) begin
         qry_pend_ff <= 1'b0;
      end
      if (cmd.qry) begin
         odd_op_ff <= (req_operation == pcst_pkg::OP_ODD);
         len_ff    <= len_wide[CW-1:0];
      end
   end

   // A result appears either at once for an empty range or when a walk ends.
   logic          res_evt;
   logic [CW-1:0] res_val;

   always_comb begin
      res_evt = 1'b0;
      res_val = '0;
      if (eng.done) begin
         res_evt = 1'b1;
         res_val = odd_op_ff ? eng.odd : (len_ff - eng.odd);
      end else if (accept && is_query && empty) begin
         res_evt = 1'b1;
      end
   end

   // Output register with one holding slot behind it.
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_count_ff;
   logic [CW-1:0] hold_count_ff;
   logic          take;

   assign take = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         priority if (hold_valid_ff) begin
            if (take) begin
               rsp_count_ff  <= hold_count_ff;
               hold_valid_ff <= 1'b0;
            end
         end else if (res_evt) begin
            if (!rsp_valid_ff || take) begin
               rsp_count_ff <= res_val;
               rsp_valid_ff <= 1'b1;
            end else begin
               hold_count_ff <= res_val;
               hold_valid_ff <= 1'b1;
            end
         end else if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

   // A walk only finishes for a query that was started.
   assert property (@(posedge clock) disable iff (reset) eng.done |-> qry_pend_ff)
      else $error("tree walk finished with no query in flight");

   // The holding slot is only used while the output register is full.
   assert property (@(posedge clock) disable iff (reset) hold_valid_ff |-> rsp_valid_ff)
      else $error("holding slot full while output register empty");

   // No new result may arrive while the holding slot is occupied.
   assert property (@(posedge clock) disable iff (reset) res_evt |-> !hold_valid_ff)
      else $error("result arrived with holding slot full");

   // A count never exceeds the array size.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> (LW'(rsp_count_ff) <= LW'(pcst_pkg::MAX_ELEMENTS)))
      else $error("count exceeds number of elements");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for parity_count_segment_tree_unit: random and directed sets and
// range queries, with a parity mirror that predicts every count.
// Depends on pcst_pkg and the unit's RTL.

module testbench;

   // Operation code 3 is accepted by the unit and then ignored.
   localparam logic [pcst_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
   localparam int STALL_LIMIT  = 20000;
   localparam int SETTLE_WAIT  = 40;
   localparam int IDLE_PERCENT = 38;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 150;

   typedef struct packed {
      logic [pcst_pkg::OP_W-1:0]    operation;
      logic [pcst_pkg::IDX_W-1:0]   index;
      logic [pcst_pkg::VALUE_W-1:0] value;
      logic [pcst_pkg::IDX_W-1:0]   left_bound;
      logic [pcst_pkg::IDX_W-1:0]   right_bound;
   } tree_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [pcst_pkg::OP_W-1:0] req_operation = pcst_pkg::OP_SET;
   logic [pcst_pkg::IDX_W-1:0] req_index = '0;
   logic [pcst_pkg::VALUE_W-1:0] req_value = '0;
   logic [pcst_pkg::IDX_W-1:0] req_left_bound = '0;
   logic [pcst_pkg::IDX_W-1:0] req_right_bound = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [pcst_pkg::CNT_W-1:0] rsp_count;
   logic csr_write_enable = 1'b0;
   logic [pcst_pkg::CNT_W-1:0] csr_write_data = '0;

   // Mirror of the stored parities and the element count register.
   bit element_parity [pcst_pkg::MAX_ELEMENTS];
   int unsigned element_limit = 1024;

   tree_request_type pending_requests[$];
   tree_request_type current_request;
   logic [pcst_pkg::CNT_W-1:0] expected_counts[$];
   int sent_total = 0;
   int accepted_total = 0;
   int results_seen = 0;
   int mismatches = 0;
   int hold_left = 0;
   int stall_cycles = 0;

   parity_count_segment_tree_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_index        (req_index),
      .req_value        (req_value),
      .req_left_bound   (req_left_bound),
      .req_right_bound  (req_right_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_count        (rsp_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Applies one accepted request to the mirror and queues the count it should return.
   function automatic void apply_request(tree_request_type r);
      int unsigned span;
      int unsigned hi;
      int unsigned odd;
      int unsigned len;
      logic [pcst_pkg::CNT_W-1:0] answer;
      if (r.operation == pcst_pkg::OP_SET) begin
         element_parity[r.index] = r.value[0];
      end else if (r.operation == pcst_pkg::OP_EVEN || r.operation == pcst_pkg::OP_ODD) begin
         span = (element_limit > pcst_pkg::MAX_ELEMENTS) ? pcst_pkg::MAX_ELEMENTS
                                                         : element_limit;
         answer = '0;
         if (span != 0) begin
            hi = (r.right_bound > span - 1) ? span - 1 : r.right_bound;
            if (r.left_bound <= hi) begin
               odd = 0;
               for (int unsigned i = r.left_bound; i <= hi; i++) odd += element_parity[i];
               len = hi - r.left_bound + 1;
               answer = (r.operation == pcst_pkg::OP_ODD) ? pcst_pkg::CNT_W'(odd)
                                                          : pcst_pkg::CNT_W'(len - odd);
            end
         end
         expected_counts.push_back(answer);
      end
   endfunction

   // Queues one request for the driver.
   task automatic queue_request(logic [pcst_pkg::OP_W-1:0] op, int unsigned idx,
                                logic [pcst_pkg::VALUE_W-1:0] val,
                                int unsigned lb, int unsigned rb);
      tree_request_type r;
      r.operation   = op;
      r.index       = pcst_pkg::IDX_W'(idx);
      r.value       = val;
      r.left_bound  = pcst_pkg::IDX_W'(lb);
      r.right_bound = pcst_pkg::IDX_W'(rb);
      pending_requests.push_back(r);
      sent_total++;
   endtask

   // Random request; positions lean toward the part of the array in use.
   function automatic tree_request_type random_request(int unsigned span);
      tree_request_type r;
      int unsigned kind;
      int unsigned reach;
      int unsigned lb;
      reach = (span + 3 > pcst_pkg::MAX_ELEMENTS - 1) ? pcst_pkg::MAX_ELEMENTS - 1 : span + 3;
      kind = $urandom_range(99, 0);
      if (kind < 45) r.operation = pcst_pkg::OP_SET;
      else if (kind < 70) r.operation = pcst_pkg::OP_EVEN;
      else if (kind < 95) r.operation = pcst_pkg::OP_ODD;
      else r.operation = OP_RESERVED;
      r.value = $urandom;
      r.index = ($urandom_range(9, 0) < 7)
                ? pcst_pkg::IDX_W'($urandom_range(reach, 0))
                : pcst_pkg::IDX_W'($urandom_range(pcst_pkg::MAX_ELEMENTS - 1, 0));
      if ($urandom_range(9, 0) < 3) begin
         r.left_bound  = pcst_pkg::IDX_W'($urandom);
         r.right_bound = pcst_pkg::IDX_W'($urandom);
      end else begin
         lb = $urandom_range(reach, 0);
         r.left_bound  = pcst_pkg::IDX_W'(lb);
         r.right_bound = ($urandom_range(3, 0) == 0)
                         ? pcst_pkg::IDX_W'($urandom_range(pcst_pkg::MAX_ELEMENTS - 1, lb))
                         : pcst_pkg::IDX_W'($urandom_range((reach > lb) ? reach : lb, lb));
      end
      return r;
   endfunction

   // Blocks until every queued request is taken and every count has come back.
   task automatic wait_until_drained();
      while (sent_total != accepted_total || expected_counts.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Request driver: offers queued requests and records each transfer.
   always @(posedge clock) begin : request_driver
      bit took;
      bit calm;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && req_ready;
         if (took) begin
            apply_request(current_request);
            accepted_total++;
         end
         calm = (accepted_total >= 500 && accepted_total < 700);
         if (!req_valid || took) begin
            if (pending_requests.size() != 0 &&
                (calm || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
               current_request = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_operation   <= current_request.operation;
               req_index       <= current_request.index;
               req_value       <= current_request.value;
               req_left_bound  <= current_request.left_bound;
               req_right_bound <= current_request.right_bound;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each count and throttles rsp_ready.
   always @(posedge clock) begin : response_monitor
      logic [pcst_pkg::CNT_W-1:0] wanted;
      bit calm;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected count %0d with nothing outstanding", rsp_count);
            end else begin
               wanted = expected_counts.pop_front();
               if (rsp_count !== wanted) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("count mismatch: expected %0d, got %0d", wanted, rsp_count);
               end
            end
            // Long back-pressure so the unit fills and drops req_ready.
            if (results_seen == 200 || results_seen == 650) hold_left = HOLD_CYCLES;
         end
         calm = (results_seen >= 300 && results_seen < 420);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99, 0) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus sequencer: directed checks, then one random phase per register setting.
   initial begin
      int unsigned phase_limits[8];
      int unsigned span;
      phase_limits = '{1, 2, 0, 2047, 1023, 513, 1024, 37};
      for (int i = 0; i < pcst_pkg::MAX_ELEMENTS; i++) element_parity[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset element count.
      queue_request(pcst_pkg::OP_EVEN, 0, 32'h0, 0, 1023);
      queue_request(pcst_pkg::OP_ODD, 0, 32'h0, 0, 1023);
      queue_request(pcst_pkg::OP_SET, 0, 32'h0000_0001, 0, 0);
      queue_request(pcst_pkg::OP_SET, 1023, 32'hFFFF_FFFF, 1023, 1023);
      queue_request(pcst_pkg::OP_SET, 512, 32'hFFFF_FFFE, 0, 0);
      queue_request(pcst_pkg::OP_SET, 7, 32'h8000_0001, 0, 0);
      queue_request(pcst_pkg::OP_SET, 7, 32'h0000_0000, 0, 0);
      queue_request(pcst_pkg::OP_SET, 8, 32'h5555_5555, 0, 0);
      queue_request(pcst_pkg::OP_ODD, 0, 32'h0, 0, 1023);
      queue_request(pcst_pkg::OP_EVEN, 0, 32'h0, 0, 1023);
      queue_request(pcst_pkg::OP_ODD, 0, 32'h0, 0, 0);
      queue_request(pcst_pkg::OP_EVEN, 0, 32'h0, 1023, 1023);
      queue_request(pcst_pkg::OP_ODD, 0, 32'h0, 1023, 1023);
      // Inverted range gives zero.
      queue_request(pcst_pkg::OP_EVEN, 0, 32'h0, 10, 5);
      queue_request(pcst_pkg::OP_ODD, 0, 32'h0, 512, 512);
      queue_request(OP_RESERVED, 1023, 32'hFFFF_FFFF, 1023, 0);
      queue_request(pcst_pkg::OP_EVEN, 0, 32'h0, 1, 1022);
      queue_request(pcst_pkg::OP_ODD, 0, 32'h0, 8, 1023);
      wait_until_drained();

      foreach (phase_limits[p]) begin
         // Register write while the unit is idle.
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data   <= pcst_pkg::CNT_W'(phase_limits[p]);
         element_limit = phase_limits[p];
         @(posedge clock);
         csr_write_enable <= 1'b0;

         // Clipping at the new setting, then random traffic.
         queue_request(pcst_pkg::OP_ODD, 0, 32'h0, 0, 1023);
         queue_request(pcst_pkg::OP_EVEN, 0, 32'h0, 0, 1023);
         queue_request(pcst_pkg::OP_EVEN, 0, 32'h0, 1023, 1023);
         span = (element_limit > pcst_pkg::MAX_ELEMENTS) ? pcst_pkg::MAX_ELEMENTS
                                                         : element_limit;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pending_requests.push_back(random_request(span));
            sent_total++;
         end
         wait_until_drained();
      end

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
